// ===== hw/rtl/gmb_pkg.sv =====
package gmb_pkg;

    localparam int MAX_VERTS_DEF = 64;
    localparam int MAX_TRIS_DEF  = 128;

    localparam int VTX_W     = 32;
    localparam int LOC_W     = 8;
    localparam int VCOUNT_W  = 9;
    localparam int TCOUNT_W  = 10;
    localparam int KIND_W    = 2;
    localparam int NUM_SLOTS = 6;

    localparam logic [KIND_W-1:0] KIND_VERTEX   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TRIANGLE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MESHLET  = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [VTX_W-1:0]    global_vertex;
        logic [LOC_W-1:0]    local_a;
        logic [LOC_W-1:0]    local_b;
        logic [LOC_W-1:0]    local_c;
        logic [VTX_W-1:0]    vertex_offset;
        logic [VTX_W-1:0]    triangle_offset;
        logic [VCOUNT_W-1:0] vertex_count;
        logic [TCOUNT_W-1:0] triangle_count;
    } result_t;

    // Fixed slot order: early close, new a, new b, new c, triangle, end close.
    typedef struct packed {
        result_t [NUM_SLOTS-1:0] slot;
        logic [NUM_SLOTS-1:0]    mask;
    } bundle_t;

endpackage

// ===== hw/rtl/greedy_meshlet_builder_core.sv =====
// The first result of a triangle is offered once the item has passed the input register
// and been loaded into the result queue; a busy queue holds it in the input register.
// A triangle gives one to six results, which leave one at a time as the output takes them;
// the input register can take the next item meanwhile and holds it until the queue is free.
// The vertex store is searched in parallel in the cycle the item leaves the input register.
// Reset clears the counters, list lengths and valid flags; the vertex store is not cleared.
module greedy_meshlet_builder_core #(
    parameter int MAX_VERTS = gmb_pkg::MAX_VERTS_DEF,
    parameter int MAX_TRIS  = gmb_pkg::MAX_TRIS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [gmb_pkg::VTX_W-1:0]        vertex_a,
    input  logic [gmb_pkg::VTX_W-1:0]        vertex_b,
    input  logic [gmb_pkg::VTX_W-1:0]        vertex_c,
    input  logic                             end_of_part,
    input  logic                             start_of_mesh,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [gmb_pkg::KIND_W-1:0]       kind,
    output logic [gmb_pkg::VTX_W-1:0]        global_vertex,
    output logic [gmb_pkg::LOC_W-1:0]        local_a,
    output logic [gmb_pkg::LOC_W-1:0]        local_b,
    output logic [gmb_pkg::LOC_W-1:0]        local_c,
    output logic [gmb_pkg::VTX_W-1:0]        vertex_offset,
    output logic [gmb_pkg::VTX_W-1:0]        triangle_offset,
    output logic [gmb_pkg::VCOUNT_W-1:0]     vertex_count,
    output logic [gmb_pkg::TCOUNT_W-1:0]     triangle_count,
    output logic                             last
);

    localparam int IDX_W = $clog2(MAX_VERTS);
    localparam int VCW   = $clog2(MAX_VERTS + 1);
    localparam int TCW   = $clog2(MAX_TRIS + 1);

    logic                            in_valid_reg;
    logic [2:0][gmb_pkg::VTX_W-1:0]  vert_reg;
    logic                            eop_reg;
    logic                            som_reg;
    logic                            take;
    logic                            q_free;

    logic [VCW-1:0]                  cam_count;
    logic [2:0]                      wr_en;
    logic [2:0][IDX_W-1:0]           wr_idx;
    logic [2:0]                      hit;
    logic [2:0][IDX_W-1:0]           hit_idx;
    gmb_pkg::bundle_t                bundle;
    gmb_pkg::result_t                res;

    assign take     = in_valid_reg && q_free;
    assign in_ready = !in_valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            vert_reg[0] <= vertex_a;
            vert_reg[1] <= vertex_b;
            vert_reg[2] <= vertex_c;
            eop_reg     <= end_of_part;
            som_reg     <= start_of_mesh;
        end
    end

    gmb_vertex_cam #(
        .MAX_VERTS (MAX_VERTS),
        .IDX_W     (IDX_W),
        .CNT_W     (VCW)
    ) u_cam (
        .clk     (clk),
        .count   (cam_count),
        .query   (vert_reg),
        .wr_en   (wr_en),
        .wr_idx  (wr_idx),
        .hit     (hit),
        .hit_idx (hit_idx)
    );

    gmb_step_ctrl #(
        .MAX_VERTS (MAX_VERTS),
        .MAX_TRIS  (MAX_TRIS),
        .IDX_W     (IDX_W),
        .VCW       (VCW),
        .TCW       (TCW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .vertices      (vert_reg),
        .end_of_part   (eop_reg),
        .start_of_mesh (som_reg),
        .hit           (hit),
        .hit_idx       (hit_idx),
        .cam_count     (cam_count),
        .wr_en         (wr_en),
        .wr_idx        (wr_idx),
        .bundle        (bundle)
    );

    gmb_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take),
        .bundle    (bundle),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .free      (q_free),
        .res       (res),
        .last      (last)
    );

    assign kind            = res.kind;
    assign global_vertex   = res.global_vertex;
    assign local_a         = res.local_a;
    assign local_b         = res.local_b;
    assign local_c         = res.local_c;
    assign vertex_offset   = res.vertex_offset;
    assign triangle_offset = res.triangle_offset;
    assign vertex_count    = res.vertex_count;
    assign triangle_count  = res.triangle_count;

endmodule

// ===== hw/rtl/gmb_vertex_cam.sv =====
module gmb_vertex_cam #(
    parameter int MAX_VERTS = gmb_pkg::MAX_VERTS_DEF,
    parameter int IDX_W     = $clog2(MAX_VERTS),
    parameter int CNT_W     = $clog2(MAX_VERTS + 1)
) (
    input  logic                                clk,
    input  logic [CNT_W-1:0]                    count,
    input  logic [2:0][gmb_pkg::VTX_W-1:0]      query,
    input  logic [2:0]                          wr_en,
    input  logic [2:0][IDX_W-1:0]               wr_idx,
    output logic [2:0]                          hit,
    output logic [2:0][IDX_W-1:0]               hit_idx
);

    logic [gmb_pkg::VTX_W-1:0] store_reg [MAX_VERTS];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_VERTS; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (wr_en[k] && wr_idx[k] == IDX_W'(i))
                begin
                    store_reg[i] <= query[k];
                end
            end
        end
    end

    // Live entries are distinct, so at most one matches and the index is an OR.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            hit[k]     = 1'b0;
            hit_idx[k] = '0;
            for (int i = 0; i < MAX_VERTS; i++)
            begin
                if (CNT_W'(i) < count && store_reg[i] == query[k])
                begin
                    hit[k]     = 1'b1;
                    hit_idx[k] = hit_idx[k] | IDX_W'(i);
                end
            end
        end
    end

endmodule

// ===== hw/rtl/gmb_step_ctrl.sv =====
module gmb_step_ctrl #(
    parameter int MAX_VERTS = gmb_pkg::MAX_VERTS_DEF,
    parameter int MAX_TRIS  = gmb_pkg::MAX_TRIS_DEF,
    parameter int IDX_W     = $clog2(MAX_VERTS),
    parameter int VCW       = $clog2(MAX_VERTS + 1),
    parameter int TCW       = $clog2(MAX_TRIS + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            take,
    input  logic [2:0][gmb_pkg::VTX_W-1:0]  vertices,
    input  logic                            end_of_part,
    input  logic                            start_of_mesh,
    input  logic [2:0]                      hit,
    input  logic [2:0][IDX_W-1:0]           hit_idx,
    output logic [VCW-1:0]                  cam_count,
    output logic [2:0]                      wr_en,
    output logic [2:0][IDX_W-1:0]           wr_idx,
    output gmb_pkg::bundle_t                bundle
);

    logic [VCW-1:0] vcnt_reg, vcnt_next;
    logic [TCW-1:0] tcnt_reg, tcnt_next;
    logic [31:0]    vlen_reg, vlen_next;
    logic [31:0]    tlen_reg, tlen_next;

    logic [VCW-1:0]   c_eff, base, vc_after;
    logic [TCW-1:0]   t_eff, tc_after;
    logic [31:0]      vlen_eff, tlen_eff, vlen_after, tlen_after;
    logic [VCW:0]     new_n, demand;
    logic             close_pre;
    logic [2:0]       h, ins;
    logic             dup_ba, dup_ca, dup_cb;
    logic [IDX_W-1:0] loc_a, loc_b, loc_c;
    logic [VCW-1:0]   pos_b, pos_c;

    function automatic gmb_pkg::result_t meshlet_rec(
        input logic [31:0] vlen,
        input logic [31:0] tlen,
        input logic [31:0] vc,
        input logic [31:0] tc
    );
        gmb_pkg::result_t r;
        r                 = '0;
        r.kind            = gmb_pkg::KIND_MESHLET;
        r.vertex_offset   = vlen - vc;
        r.triangle_offset = tlen - ((tc << 1) + tc);
        r.vertex_count    = vc[gmb_pkg::VCOUNT_W-1:0];
        r.triangle_count  = tc[gmb_pkg::TCOUNT_W-1:0];
        return r;
    endfunction

    function automatic gmb_pkg::result_t vertex_rec(input logic [gmb_pkg::VTX_W-1:0] v);
        gmb_pkg::result_t r;
        r               = '0;
        r.kind          = gmb_pkg::KIND_VERTEX;
        r.global_vertex = v;
        return r;
    endfunction

    assign c_eff     = start_of_mesh ? '0 : vcnt_reg;
    assign t_eff     = start_of_mesh ? '0 : tcnt_reg;
    assign vlen_eff  = start_of_mesh ? '0 : vlen_reg;
    assign tlen_eff  = start_of_mesh ? '0 : tlen_reg;
    assign cam_count = c_eff;

    // Every store miss counts as new here, repeats within the triangle included.
    assign new_n  = (VCW+1)'(!hit[0]) + (VCW+1)'(!hit[1]) + (VCW+1)'(!hit[2]);
    assign demand = {1'b0, c_eff} + new_n;

    assign close_pre = (t_eff != '0) &&
                       ((t_eff >= TCW'(MAX_TRIS)) || (demand > (VCW+1)'(MAX_VERTS)));

    // A close empties the store, so nothing found there still counts.
    assign base = close_pre ? '0 : c_eff;
    assign h    = close_pre ? 3'b000 : hit;

    assign dup_ba = vertices[1] == vertices[0];
    assign dup_ca = vertices[2] == vertices[0];
    assign dup_cb = vertices[2] == vertices[1];

    assign ins[0] = !h[0];
    assign ins[1] = !h[1] && !dup_ba;
    assign ins[2] = !h[2] && !dup_ca && !dup_cb;

    assign pos_b = base + VCW'(ins[0]);
    assign pos_c = pos_b + VCW'(ins[1]);

    assign loc_a = h[0] ? hit_idx[0] : base[IDX_W-1:0];
    assign loc_b = h[1] ? hit_idx[1] : (dup_ba ? loc_a : pos_b[IDX_W-1:0]);
    assign loc_c = h[2] ? hit_idx[2] :
                   (dup_ca ? loc_a : (dup_cb ? loc_b : pos_c[IDX_W-1:0]));

    assign wr_en     = take ? ins : 3'b000;
    assign wr_idx[0] = base[IDX_W-1:0];
    assign wr_idx[1] = pos_b[IDX_W-1:0];
    assign wr_idx[2] = pos_c[IDX_W-1:0];

    assign vc_after   = pos_c + VCW'(ins[2]);
    assign tc_after   = (close_pre ? '0 : t_eff) + TCW'(1);
    assign vlen_after = vlen_eff + 32'(ins[0]) + 32'(ins[1]) + 32'(ins[2]);
    assign tlen_after = tlen_eff + 32'd3;

    always_comb
    begin
        bundle = '0;
        bundle.slot[0] = meshlet_rec(vlen_eff, tlen_eff, 32'(c_eff), 32'(t_eff));
        bundle.slot[1] = vertex_rec(vertices[0]);
        bundle.slot[2] = vertex_rec(vertices[1]);
        bundle.slot[3] = vertex_rec(vertices[2]);
        bundle.slot[4].kind    = gmb_pkg::KIND_TRIANGLE;
        bundle.slot[4].local_a = gmb_pkg::LOC_W'(loc_a);
        bundle.slot[4].local_b = gmb_pkg::LOC_W'(loc_b);
        bundle.slot[4].local_c = gmb_pkg::LOC_W'(loc_c);
        bundle.slot[5] = meshlet_rec(vlen_after, tlen_after, 32'(vc_after), 32'(tc_after));
        bundle.mask    = {end_of_part, 1'b1, ins, close_pre};
    end

    assign vcnt_next = end_of_part ? '0 : vc_after;
    assign tcnt_next = end_of_part ? '0 : tc_after;
    assign vlen_next = vlen_after;
    assign tlen_next = tlen_after;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcnt_reg <= '0;
            tcnt_reg <= '0;
            vlen_reg <= '0;
            tlen_reg <= '0;
        end
        else if (take)
        begin
            vcnt_reg <= vcnt_next;
            tcnt_reg <= tcnt_next;
            vlen_reg <= vlen_next;
            tlen_reg <= tlen_next;
        end
    end

endmodule

// ===== hw/rtl/gmb_result_queue.sv =====
module gmb_result_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  gmb_pkg::bundle_t     bundle,
    input  logic                 out_ready,
    output logic                 out_valid,
    output logic                 free,
    output gmb_pkg::result_t     res,
    output logic                 last
);

    gmb_pkg::result_t [gmb_pkg::NUM_SLOTS-1:0] slot_reg;
    logic [gmb_pkg::NUM_SLOTS-1:0]             mask_reg, mask_next;
    logic                                      pop;

    assign out_valid = mask_reg != '0;
    assign pop       = out_valid && out_ready;
    // Clearing the lowest set bit retires the item on display.
    assign mask_next = mask_reg & (mask_reg - gmb_pkg::NUM_SLOTS'(1));
    assign last      = mask_next == '0;
    assign free      = !out_valid || (pop && last);

    always_comb
    begin
        res = '0;
        for (int i = gmb_pkg::NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                res = slot_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else if (load)
        begin
            mask_reg <= bundle.mask;
        end
        else if (pop)
        begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot_reg <= bundle.slot;
        end
    end

endmodule
